@@ sv/midi_timecode_decoder_defines.svh @@
// Assertion macros for the MIDI time code decoder.
// Depends on nothing; included by the top level only.
`ifndef MIDI_TIMECODE_DECODER_DEFINES_SVH
`define MIDI_TIMECODE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("MTC assertion failed");
`define MTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("MTC assertion failed");
`else
`define MTC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/mtc_pkg.sv @@
// Shared types, codes and constants of the MIDI time code decoder.
// Depends on nothing; used by every module of the block.
package mtc_pkg;

    typedef enum logic [1:0] {
        OP_QF    = 2'd0,
        OP_SYSEX = 2'd1,
        OP_REQ   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [7:0] SX_START  = 8'hF0;
    localparam logic [7:0] SX_RT_ID  = 8'h7F;
    localparam logic [7:0] SX_MTC_ID = 8'h01;
    localparam logic [7:0] SX_STOP   = 8'hF7;

    localparam logic [3:0] SX_HDR_LEN   = 4'd5;
    localparam logic [3:0] SX_CAP_FIRST = 4'd5;
    localparam logic [3:0] SX_CAP_END   = 4'd9;
    localparam logic [3:0] SX_END_POS   = 4'd9;
    localparam logic [3:0] SX_MAX_POS   = 4'd15;

    localparam logic [2:0] QF_LAST_PIECE = 3'd7;

    localparam int H_PROD_W = 17;
    localparam int M_PROD_W = 14;
    localparam int MS_W     = 32;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

    localparam logic [3:0] PKT_LAST_IDX = 4'd12;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic qf_wr;
        logic sx_wr;
        logic snap;
        logic mul;
        logic cnt_clr;
        logic cnt_inc;
    } t_dp_cmd;

    // Datapath status returned to the controller.
    typedef struct packed {
        logic cnt_last;
    } t_dp_sts;

    // Expected full-frame header byte at positions 0 to 4.
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:         b = SX_START;
            3'd1, 3'd2:   b = SX_RT_ID;
            3'd3, 3'd4:   b = SX_MTC_ID;
            default:      b = SX_START;
        endcase
        return b;
    endfunction

endpackage

@@ sv/mtc_datapath.sv @@
// Datapath of the MIDI time code decoder: timecode state, sysex parser,
// millisecond arithmetic and packet byte selection. Depends on mtc_pkg.
module mtc_datapath import mtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_sysex_end,
    input  logic [63:0] i_wall_clock_ms,
    output t_dp_sts     o_sts,
    output logic [7:0]  o_packet_byte,
    output logic [3:0]  o_packet_index,
    output logic        o_packet_last
);

    logic [3:0]          r_nib [8];
    logic [3:0]          n_nib [8];
    logic [4:0]          r_tc_hours, n_tc_hours;
    logic [7:0]          r_tc_min, n_tc_min;
    logic [7:0]          r_tc_sec, n_tc_sec;
    logic [7:0]          r_tc_frm, n_tc_frm;
    logic [3:0]          r_sx_count;
    logic                r_sx_hdr_ok;
    logic [7:0]          r_sx_cap [4];
    logic [H_PROD_W-1:0] r_h_prod;
    logic [M_PROD_W-1:0] r_m_prod;
    logic [7:0]          r_sec;
    logic [7:0]          r_frm;
    logic [63:0]         r_wall;
    logic [MS_W-1:0]     r_ms;
    logic [3:0]          r_idx;

    logic [2:0]          qf_piece;
    logic                qf_full;
    logic [3:0]          sx_pos;
    logic [3:0]          sx_cap_off;
    logic                sx_in_hdr;
    logic                sx_in_cap;
    logic                sx_mismatch;
    logic                sx_take;
    logic [H_PROD_W-1:0] sec_sum;

    assign qf_piece   = i_data_byte[6:4];
    assign qf_full    = i_cmd.qf_wr && (qf_piece == QF_LAST_PIECE);
    assign sx_pos     = r_sx_count;
    assign sx_cap_off = sx_pos - SX_CAP_FIRST;
    assign sx_in_hdr  = sx_pos < SX_HDR_LEN;
    assign sx_in_cap  = (sx_pos >= SX_CAP_FIRST) && (sx_pos < SX_CAP_END);
    assign sx_mismatch = sx_in_hdr && (i_data_byte != hdr_byte(sx_pos[2:0]));
    assign sx_take    = i_cmd.sx_wr && i_sysex_end && (sx_pos == SX_END_POS)
                        && (i_data_byte == SX_STOP) && r_sx_hdr_ok;

    always_comb begin
        n_nib = r_nib;
        if (i_cmd.qf_wr) begin
            n_nib[qf_piece] = i_data_byte[3:0];
        end
    end

    // Piece 7 assembles from the nibbles including the one just written.
    always_comb begin
        n_tc_hours = r_tc_hours;
        n_tc_min   = r_tc_min;
        n_tc_sec   = r_tc_sec;
        n_tc_frm   = r_tc_frm;
        priority if (qf_full) begin
            n_tc_frm   = {3'b000, n_nib[1][0], n_nib[0]};
            n_tc_sec   = {1'b0, n_nib[3][2:0], n_nib[2]};
            n_tc_min   = {1'b0, n_nib[5][2:0], n_nib[4]};
            n_tc_hours = {n_nib[7][0], n_nib[6]};
        end else if (sx_take) begin
            n_tc_hours = r_sx_cap[0][4:0];
            n_tc_min   = r_sx_cap[1];
            n_tc_sec   = r_sx_cap[2];
            n_tc_frm   = r_sx_cap[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_nib[i] <= 4'd0;
            end
            r_tc_hours  <= 5'd0;
            r_tc_min    <= 8'd0;
            r_tc_sec    <= 8'd0;
            r_tc_frm    <= 8'd0;
            r_sx_count  <= 4'd0;
            r_sx_hdr_ok <= 1'b1;
            r_idx       <= 4'd0;
        end else begin
            r_nib      <= n_nib;
            r_tc_hours <= n_tc_hours;
            r_tc_min   <= n_tc_min;
            r_tc_sec   <= n_tc_sec;
            r_tc_frm   <= n_tc_frm;
            if (i_cmd.sx_wr) begin
                if (i_sysex_end) begin
                    r_sx_count  <= 4'd0;
                    r_sx_hdr_ok <= 1'b1;
                end else begin
                    if (sx_mismatch) begin
                        r_sx_hdr_ok <= 1'b0;
                    end
                    if (sx_pos != SX_MAX_POS) begin
                        r_sx_count <= sx_pos + 4'd1;
                    end
                end
            end
            if (i_cmd.cnt_clr) begin
                r_idx <= 4'd0;
            end else if (i_cmd.cnt_inc) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Capture bytes and arithmetic registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sx_wr && sx_in_cap) begin
            r_sx_cap[sx_cap_off[1:0]] <= i_data_byte;
        end
        if (i_cmd.snap) begin
            r_h_prod <= H_PROD_W'(r_tc_hours) * H_PROD_W'(SEC_PER_HOUR);
            r_m_prod <= M_PROD_W'(r_tc_min) * M_PROD_W'(SEC_PER_MIN);
            r_sec    <= r_tc_sec;
            r_frm    <= r_tc_frm;
            r_wall   <= i_wall_clock_ms;
        end
        if (i_cmd.mul) begin
            r_ms <= MS_W'(sec_sum) * MS_W'(MS_PER_SEC);
        end
    end

    assign sec_sum = r_h_prod + H_PROD_W'(r_m_prod) + H_PROD_W'(r_sec);

    always_comb begin
        unique case (r_idx)
            4'd0:    o_packet_byte = r_ms[31:24];
            4'd1:    o_packet_byte = r_ms[23:16];
            4'd2:    o_packet_byte = r_ms[15:8];
            4'd3:    o_packet_byte = r_ms[7:0];
            4'd4:    o_packet_byte = r_frm;
            4'd5:    o_packet_byte = r_wall[63:56];
            4'd6:    o_packet_byte = r_wall[55:48];
            4'd7:    o_packet_byte = r_wall[47:40];
            4'd8:    o_packet_byte = r_wall[39:32];
            4'd9:    o_packet_byte = r_wall[31:24];
            4'd10:   o_packet_byte = r_wall[23:16];
            4'd11:   o_packet_byte = r_wall[15:8];
            4'd12:   o_packet_byte = r_wall[7:0];
            default: o_packet_byte = 8'h00;
        endcase
    end

    assign o_sts.cnt_last = (r_idx == PKT_LAST_IDX);
    assign o_packet_index = r_idx;
    assign o_packet_last  = o_sts.cnt_last;

endmodule

@@ sv/mtc_ctrl.sv @@
// Controller of the MIDI time code decoder: handshakes and sequencing.
// Depends on mtc_pkg.
module mtc_ctrl import mtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  logic       i_ready,
    input  t_dp_sts    i_sts,
    output logic       o_ready,
    output logic       o_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_SEND);
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_op == OP_REQ)) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_ready && i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.qf_wr   = acc && (i_op == OP_QF);
        o_cmd.sx_wr   = acc && (i_op == OP_SYSEX);
        o_cmd.snap    = acc && (i_op == OP_REQ);
        o_cmd.mul     = (r_state == S_CALC);
        o_cmd.cnt_clr = o_cmd.snap;
        o_cmd.cnt_inc = o_valid && i_ready && !i_sts.cnt_last;
    end

endmodule

@@ sv/midi_timecode_decoder.sv @@
// Top level of the MIDI time code decoder: controller plus datapath.
// Depends on mtc_pkg, mtc_ctrl, mtc_datapath and the defines header.
//
//   Channel   Direction  Handshake            Payload
//   request   in         i_valid / o_ready    i_op, i_data_byte, i_sysex_end,
//                                             i_wall_clock_ms
//   packet    out        o_valid / i_ready    o_packet_byte, o_packet_index,
//                                             o_packet_last
//
// Quarter-frame and sysex requests may be accepted in every cycle while
// o_ready is high; they produce no packet bytes. A frame request forms the
// partial products as it is accepted, then performs the multiply by 1000,
// then presents 13 bytes, one per cycle while i_ready stays high;
// o_ready returns the cycle after the last byte is taken. A stall on the
// packet side holds the current byte and index. Reset is synchronous and
// active low, and needs no clearing pass.
`include "midi_timecode_decoder_defines.svh"

module midi_timecode_decoder import mtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_sysex_end,
    input  logic [63:0] i_wall_clock_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_packet_byte,
    output logic [3:0]  o_packet_index,
    output logic        o_packet_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller owns both handshakes; the datapath only follows
    // its commands and reports when the final byte is on show.
    mtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    // The timecode cannot change while a packet is in flight, because no
    // request is accepted until the last byte has been taken.
    mtc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_data_byte     (i_data_byte),
        .i_sysex_end     (i_sysex_end),
        .i_wall_clock_ms (i_wall_clock_ms),
        .o_sts           (dp_sts),
        .o_packet_byte   (o_packet_byte),
        .o_packet_index  (o_packet_index),
        .o_packet_last   (o_packet_last)
    );

    // No request is taken while packet bytes are outstanding.
    `MTC_ASSERT_SAME(a_no_accept_in_packet, i_clk, i_rst_n, o_valid, !o_ready)
    // A frame request blocks the input side in the following cycle.
    `MTC_ASSERT_NEXT(a_req_blocks, i_clk, i_rst_n, i_valid && o_ready && (i_op == OP_REQ), !o_ready)
    // A taken byte that is not the last is followed by the next index.
    `MTC_ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_valid && i_ready && !o_packet_last, o_valid && (o_packet_index == 4'($past(o_packet_index) + 4'd1)))
    // Taking the last byte frees the block at once.
    `MTC_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_valid && i_ready && o_packet_last, o_ready && !o_valid)

endmodule
